/* src/dhtq_pkg.sv */
`timescale 1ns / 1ps
package dhtq_pkg;
  localparam int DEF_HEAP_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TIME_W = 48;
  localparam int IVAL_W = 32;
  localparam int ID_W = 8;
  localparam int SEQ_W = 16;
  localparam int MINIV_W = 16;
  localparam int KIND_W = 3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADDED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SHORT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIRED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd4;

  localparam int ENTRY_W = TIME_W + IVAL_W + ID_W + 1 + SEQ_W;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [IVAL_W-1:0] interval;
    logic [ID_W-1:0] id;
    logic rpt;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  function automatic logic earlier(entry_t a, entry_t b);
    logic [SEQ_W-1:0] d;
    d = a.seq - b.seq;
    if (a.deadline != b.deadline) return a.deadline < b.deadline;
    return d[SEQ_W-1];
  endfunction

  function automatic logic [TIME_W-1:0] deadline_of(logic [TIME_W-1:0] now,
                                                  logic [IVAL_W-1:0] iv);
    logic [TIME_W:0] t;
    t = {1'b0, now} + {{(TIME_W + 1 - IVAL_W){1'b0}}, iv};
    return t[TIME_W] ? {TIME_W{1'b1}} : t[TIME_W-1:0];
  endfunction
endpackage

/* src/dhtq_in_if.sv */
`timescale 1ns / 1ps
interface dhtq_in_if;
  import dhtq_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [ID_W-1:0] task_id;
  logic [IVAL_W-1:0] interval;
  logic repeat_req;
  logic [TIME_W-1:0] now_ms;
  modport source(output valid, opcode, task_id, interval, repeat_req, now_ms, input ready);
  modport sink(input valid, opcode, task_id, interval, repeat_req, now_ms, output ready);
endinterface

/* src/dhtq_out_if.sv */
`timescale 1ns / 1ps
interface dhtq_out_if;
  import dhtq_pkg::*;
  logic valid;
  logic ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0] fired_id;
  logic last;
  modport source(output valid, kind, fired_id, last, input ready);
  modport sink(input valid, kind, fired_id, last, output ready);
endinterface

/* src/dhtq_ram.sv */
`timescale 1ns / 1ps
module dhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* src/deadline_heap_timer_queue.sv */
`timescale 1ns / 1ps
// Deadline-ordered timer queue. Tasks live in a binary min-heap held in one
// RAM with a registered read (one entry read and one written per cycle). Add
// beats push a task with deadline now_ms+interval. Tick beats pop and report
// every due task (at most 16), earliest deadline first, ties in insertion
// order, then re-arm the repeating ones. Clear empties the heap. Every input
// beat gives one or more result beats, and the final one is flagged last.
// Steps per input beat:
// - Reject, clear and the unused opcode answer straight from idle.
// - An add sifts up, reading and then comparing with the parent per level.
// - A tick reads and then checks the top of the heap on each look. Each popped
//   task but the last one left fetches the last entry, then reads both children
//   and compares on each step while that entry sinks. Each re-arm takes a step
//   of its own plus an add's sift, and a final step closes the burst.
// The re-arm list is a 16-deep register file. Each fire is held in the engine
// until the next pop, or the end of the tick, shows whether it is the last.
// Result beats leave through a single output register; a fire or the end of a
// tick stalls the engine while it is full and untaken. The block accepts one
// beat at a time and raises in_ready only when idle and the register is free.
module deadline_heap_timer_queue #(
  parameter int HEAP_DEPTH = dhtq_pkg::DEF_HEAP_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [dhtq_pkg::MINIV_W-1:0] cfg_wdata,
  dhtq_in_if.sink in_ch,
  dhtq_out_if.source out_ch
);
  import dhtq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);
  localparam int RW = $clog2(MAX_RESULTS);

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH_RD, S_PUSH_CMP, S_TOP_RD, S_TOP_CHK, S_LAST_RD, S_POP_LR,
    S_POP_RR, S_POP_CMP, S_REARM, S_EMIT_END
  } state_t;

  state_t state_r;
  logic [MINIV_W-1:0] min_iv_r;
  logic [CW-1:0] count_r;
  logic [SEQ_W-1:0] seq_r;
  logic [TIME_W-1:0] now_r;
  entry_t cur_r, lch_r;
  logic [AW-1:0] pos_r;
  logic [AW:0] child_r;
  logic [NW-1:0] nfire_r;
  logic [NW-1:0] nre_r, re_idx_r;
  logic [IVAL_W-1:0] re_iv_r [MAX_RESULTS];
  logic [ID_W-1:0] re_id_r [MAX_RESULTS];
  logic [ID_W-1:0] pend_id_r;
  logic in_tick_r;

  logic o_valid_r, o_last_r;
  logic [KIND_W-1:0] o_kind_r;
  logic [ID_W-1:0] o_id_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  dhtq_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata(ENTRY_W'(wdata)), .raddr, .rdata(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  logic out_free;
  assign out_free = !o_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign out_ch.valid = o_valid_r;
  assign out_ch.kind = o_kind_r;
  assign out_ch.fired_id = o_id_r;
  assign out_ch.last = o_last_r;

  logic [AW-1:0] parent;
  assign parent = AW'((pos_r - 1'b1) >> 1);

  logic sel_r_c;
  entry_t best_c;
  logic [AW:0] best_idx_c;
  logic lch_ok, rch_ok;
  always_comb begin
    lch_ok = child_r < (AW+1)'(count_r);
    rch_ok = (child_r + 1'b1) < (AW+1)'(count_r);
    sel_r_c = rch_ok && earlier(rdata, lch_r);
    best_c = sel_r_c ? rdata : lch_r;
    best_idx_c = sel_r_c ? child_r + 1'b1 : child_r;
  end

  // Combinational read address / write control per state.
  always_comb begin
    we = 1'b0;
    waddr = pos_r;
    wdata = cur_r;
    raddr = '0;
    unique case (state_r)
      S_PUSH_RD: raddr = parent;
      S_PUSH_CMP: begin
        // rdata holds parent; move parent down or place the new entry
        we = 1'b1;
        wdata = (pos_r != '0 && earlier(cur_r, rdata)) ? rdata : cur_r;
      end
      S_LAST_RD: raddr = AW'(count_r);
      S_POP_LR: raddr = AW'(child_r);
      S_POP_RR: raddr = AW'(child_r + 1'b1);
      S_POP_CMP: begin
        // move the better child up into the hole, or settle the moved entry
        we = 1'b1;
        wdata = (lch_ok && earlier(best_c, cur_r)) ? best_c : cur_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      min_iv_r <= MINIV_W'(1);
      count_r <= '0;
      seq_r <= '0;
      o_valid_r <= 1'b0;
      nfire_r <= '0;
      nre_r <= '0;
      re_idx_r <= '0;
      in_tick_r <= 1'b0;
    end else begin
      if (cfg_we) min_iv_r <= cfg_wdata;
      if (out_ch.ready) o_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          now_r <= in_ch.now_ms;
          o_id_r <= in_ch.task_id;
          o_last_r <= 1'b1;
          case (in_ch.opcode)
            OP_ADD: begin
              o_valid_r <= 1'b1;
              if (count_r >= CW'(HEAP_DEPTH)) o_kind_r <= KIND_FULL;
              else if (in_ch.interval != '0 &&
                       in_ch.interval < IVAL_W'(min_iv_r)) o_kind_r <= KIND_SHORT;
              else begin
                o_kind_r <= KIND_ADDED;
                cur_r <= '{deadline_of(in_ch.now_ms, in_ch.interval),
                           in_ch.interval, in_ch.task_id, in_ch.repeat_req, seq_r};
                seq_r <= seq_r + 1'b1;
                pos_r <= AW'(count_r);
                count_r <= count_r + 1'b1;
                in_tick_r <= 1'b0;
                state_r <= S_PUSH_RD;
              end
            end
            OP_TICK: begin
              nfire_r <= '0;
              nre_r <= '0;
              re_idx_r <= '0;
              in_tick_r <= 1'b1;
              state_r <= S_TOP_RD;
            end
            OP_CLEAR: begin
              count_r <= '0;
              o_valid_r <= 1'b1; o_kind_r <= KIND_NONE; o_id_r <= '0;
            end
            default: begin
              o_valid_r <= 1'b1; o_kind_r <= KIND_NONE; o_id_r <= '0;
            end
          endcase
        end
        S_PUSH_RD: state_r <= S_PUSH_CMP;
        S_PUSH_CMP: begin
          if (pos_r != '0 && earlier(cur_r, rdata)) begin
            pos_r <= parent;
            state_r <= S_PUSH_RD;
          end else state_r <= in_tick_r ? S_REARM : S_IDLE;
        end
        S_TOP_RD: state_r <= S_TOP_CHK;
        S_TOP_CHK: begin
          if (count_r != '0 && nfire_r != NW'(MAX_RESULTS) && rdata.deadline <= now_r) begin
            // send the held fire as not last, then hold this one
            if (nfire_r == '0 || out_free) begin
              if (nfire_r != '0) begin
                o_valid_r <= 1'b1; o_kind_r <= KIND_FIRED; o_id_r <= pend_id_r;
                o_last_r <= 1'b0;
              end
              pend_id_r <= rdata.id;
              nfire_r <= nfire_r + 1'b1;
              if (rdata.rpt) begin
                re_iv_r[RW'(nre_r)] <= rdata.interval;
                re_id_r[RW'(nre_r)] <= rdata.id;
                nre_r <= nre_r + 1'b1;
              end
              count_r <= count_r - 1'b1;
              state_r <= (count_r == CW'(1)) ? S_TOP_RD : S_LAST_RD;
            end
          end else state_r <= S_REARM;
        end
        S_LAST_RD: begin
          pos_r <= '0;
          child_r <= (AW+1)'(1);
          state_r <= S_POP_LR;
        end
        S_POP_LR: begin
          if (child_r == (AW+1)'(1)) cur_r <= rdata; // moved last entry
          state_r <= S_POP_RR;
        end
        S_POP_RR: begin
          lch_r <= rdata;
          state_r <= S_POP_CMP;
        end
        S_POP_CMP: begin
          if (lch_ok && earlier(best_c, cur_r)) begin
            // descend into the child's slot; past the leaves, settle next cycle
            pos_r <= AW'(best_idx_c);
            if (((AW+2)'({best_idx_c, 1'b1})) < (AW+2)'(count_r)) begin
              child_r <= (AW+1)'({best_idx_c, 1'b1});
              state_r <= S_POP_LR;
            end else begin
              child_r <= '1;
              state_r <= S_POP_CMP;
            end
          end else state_r <= S_TOP_RD;
        end
        S_REARM: begin
          if (re_idx_r == nre_r) state_r <= S_EMIT_END;
          else begin
            re_idx_r <= re_idx_r + 1'b1;
            if (count_r < CW'(HEAP_DEPTH)) begin
              cur_r <= '{deadline_of(now_r, re_iv_r[RW'(re_idx_r)]),
                         re_iv_r[RW'(re_idx_r)], re_id_r[RW'(re_idx_r)], 1'b1, seq_r};
              seq_r <= seq_r + 1'b1;
              pos_r <= AW'(count_r);
              count_r <= count_r + 1'b1;
              state_r <= S_PUSH_RD;
            end
          end
        end
        S_EMIT_END: if (out_free) begin
          // close the burst: send the held fire as last, or report none
          o_valid_r <= 1'b1;
          o_last_r <= 1'b1;
          if (nfire_r == '0) begin
            o_kind_r <= KIND_NONE; o_id_r <= '0;
          end else begin
            o_kind_r <= KIND_FIRED; o_id_r <= pend_id_r;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hold a stalled result beat steady until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.kind) &&
      $stable(out_ch.fired_id) && $stable(out_ch.last));
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HEAP_DEPTH));
  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nfire_r <= NW'(MAX_RESULTS));
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE && !(out_ch.valid && !out_ch.ready));
endmodule
